### hw/rtl/gbra_pkg.sv
package gbra_pkg;

    // Table sizes
    localparam int MAX_RANGES  = 256;
    localparam int MAX_PENDING = 16;
    localparam int RANGE_AW    = $clog2(MAX_RANGES);
    localparam int RANGE_CW    = $clog2(MAX_RANGES + 1);
    localparam int PEND_AW     = $clog2(MAX_PENDING);
    localparam int PEND_CW     = $clog2(MAX_PENDING + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_STRIDE   = 2'd0;
    localparam logic [1:0] CFG_INIT_CAP = 2'd1;
    localparam logic [1:0] CFG_MAX_CAP  = 2'd2;

    // Request types
    localparam logic [1:0] REQ_BEGIN   = 2'd0;
    localparam logic [1:0] REQ_OBSERVE = 2'd1;
    localparam logic [1:0] REQ_RETIRE  = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    // Status codes
    localparam logic [3:0] ST_ADDED         = 4'd0;
    localparam logic [3:0] ST_REUSED        = 4'd1;
    localparam logic [3:0] ST_RESIZED       = 4'd2;
    localparam logic [3:0] ST_BAD_WORLD     = 4'd3;
    localparam logic [3:0] ST_BAD_KEY       = 4'd4;
    localparam logic [3:0] ST_BAD_COUNT     = 4'd5;
    localparam logic [3:0] ST_BAD_STRIDE    = 4'd6;
    localparam logic [3:0] ST_RETIRED_KEY   = 4'd7;
    localparam logic [3:0] ST_CAP_EXCEEDED  = 4'd8;
    localparam logic [3:0] ST_RETIRED       = 4'd9;
    localparam logic [3:0] ST_NOT_FOUND     = 4'd10;
    localparam logic [3:0] ST_ALREADY_RET   = 4'd11;
    localparam logic [3:0] ST_WORLD_BEGUN   = 4'd12;
    localparam logic [3:0] ST_WORLD_REJECT  = 4'd13;
    localparam logic [3:0] ST_RELEASED      = 4'd14;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_GROW,
        S_APPLY,
        S_REL_RD,
        S_REL_CHK,
        S_MUL_OFF,
        S_MUL_CNT,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] offset;
        logic [31:0] count;
        logic [31:0] revision;
        logic [31:0] first_frame;
        logic [31:0] last_frame;
        logic        active;
    } range_entry_t;

    typedef struct packed {
        logic [31:0] gen;
        logic [31:0] capacity;
        logic [31:0] frame;
    } pend_entry_t;

endpackage

### hw/rtl/growing_bump_range_allocator.sv
// Bump allocator for per-key vertex ranges in a storage that doubles on demand.
// One request is worked on at a time; a finished result sits in the output
// register so the next request can be taken while it waits. Begin-world goes
// from the execute state through S_MUL_OFF and S_MUL_CNT to the result
// register. Observe and retire search the range table held in a synchronous
// RAM one entry per cycle; a range that is added or written with a new size
// then passes through the apply state, and when the storage must grow, the
// capacity is first doubled one step at a time (at most 32). Release walks
// the pending list, reading each entry and then keeping or dropping it. The
// byte offset and then the byte count are formed on one shared 32x16 multiplier.
module growing_bump_range_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] world_gen,
    input  logic [31:0] key_id,
    input  logic        key_valid,
    input  logic        key_is_skinned,
    input  logic [31:0] vertex_count,
    input  logic [31:0] frame_index,
    input  logic [31:0] completed_gen,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [31:0] vertex_offset,
    output logic [47:0] byte_offset,
    output logic [47:0] byte_count,
    output logic [31:0] alloc_revision,
    output logic [31:0] storage_gen_out,
    output logic [31:0] capacity_out,
    output logic [gbra_pkg::PEND_CW-1:0]  released_count,
    output logic [gbra_pkg::PEND_CW-1:0]  pending_count,
    output logic [31:0] active_vertices_out,
    output logic [gbra_pkg::RANGE_CW-1:0] active_ranges_out
);

    localparam int RAW = gbra_pkg::RANGE_AW;
    localparam int RCW = gbra_pkg::RANGE_CW;
    localparam int PAW = gbra_pkg::PEND_AW;
    localparam int PCW = gbra_pkg::PEND_CW;

    // Configuration registers
    logic [15:0] stride_reg;
    logic [31:0] init_cap_reg;
    logic [31:0] max_cap_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg   <= '0;
            init_cap_reg <= '0;
            max_cap_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gbra_pkg::CFG_STRIDE:   stride_reg   <= cfg_data[15:0];
                gbra_pkg::CFG_INIT_CAP: init_cap_reg <= cfg_data;
                gbra_pkg::CFG_MAX_CAP:  max_cap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Range table and pending list memories
    gbra_pkg::range_entry_t range_mem [gbra_pkg::MAX_RANGES];
    gbra_pkg::pend_entry_t  pend_mem  [gbra_pkg::MAX_PENDING];

    logic                   rm_we, rm_re;
    logic [RAW-1:0]         rm_waddr, rm_raddr;
    gbra_pkg::range_entry_t rm_wdata, rm_rdata_reg;
    logic                   pm_we, pm_re;
    logic [PAW-1:0]         pm_waddr, pm_raddr;
    gbra_pkg::pend_entry_t  pm_wdata, pm_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (rm_we)
            range_mem[rm_waddr] <= rm_wdata;
        if (rm_re)
            rm_rdata_reg <= range_mem[rm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            pend_mem[pm_waddr] <= pm_wdata;
        if (pm_re)
            pm_rdata_reg <= pend_mem[pm_raddr];
    end

    // Control and allocator state
    gbra_pkg::fsm_t state_reg, state_next;

    logic [1:0]  req_reg, req_next;
    logic [31:0] world_reg, world_next;
    logic [31:0] key_reg, key_next;
    logic        kvalid_reg, kvalid_next;
    logic        skin_reg, skin_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] frame_reg, frame_next;
    logic [31:0] done_reg, done_next;

    logic [RCW-1:0] ranges_used_reg, ranges_used_next;
    logic [31:0]    cur_world_reg, cur_world_next;
    logic [31:0]    cur_gen_reg, cur_gen_next;
    logic [31:0]    next_gen_reg, next_gen_next;
    logic [31:0]    cap_reg, cap_next;
    logic [31:0]    used_reg, used_next;
    logic [31:0]    av_reg, av_next;
    logic [RCW-1:0] ar_reg, ar_next;
    logic [PCW-1:0] pend_used_reg, pend_used_next;

    // Search, growth and release working registers
    logic [RCW-1:0] scan_reg, scan_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [RAW-1:0] chk_idx_reg, chk_idx_next;
    logic           found_reg, found_next;
    logic [RAW-1:0] idx_reg, idx_next;
    logic [32:0]    need_reg, need_next;
    logic [31:0]    cap_w_reg, cap_w_next;
    logic [PCW-1:0] rel_i_reg, rel_i_next;
    logic [PCW-1:0] rel_j_reg, rel_j_next;
    logic [PCW-1:0] rel_cnt_reg, rel_cnt_next;

    // Result being built
    logic [3:0]  st_reg, st_next;
    logic [31:0] ovo_reg, ovo_next;
    logic [31:0] ocnt_reg, ocnt_next;
    logic [31:0] orev_reg, orev_next;
    logic [47:0] boff_reg, boff_next;
    logic [47:0] bcnt_reg, bcnt_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  o_status_reg, o_status_next;
    logic [31:0] o_voff_reg, o_voff_next;
    logic [47:0] o_boff_reg, o_boff_next;
    logic [47:0] o_bcnt_reg, o_bcnt_next;
    logic [31:0] o_rev_reg, o_rev_next;
    logic [31:0] o_gen_reg, o_gen_next;
    logic [31:0] o_cap_reg, o_cap_next;
    logic [PCW-1:0] o_rel_reg, o_rel_next;
    logic [PCW-1:0] o_pend_reg, o_pend_next;
    logic [31:0] o_av_reg, o_av_next;
    logic [RCW-1:0] o_ar_reg, o_ar_next;

    // Shared multiplier: vertices times stride
    logic [31:0] mul_a;
    logic [47:0] mul_p;

    assign mul_a = (state_reg == gbra_pkg::S_MUL_CNT) ? ocnt_reg : ovo_reg;
    assign mul_p = {16'd0, mul_a} * {32'd0, stride_reg};

    // Next state and datapath
    always_comb
    begin
        gbra_pkg::range_entry_t e;
        gbra_pkg::pend_entry_t  p;
        logic [32:0] required;
        logic [31:0] new_cap;
        logic [31:0] gen_a;
        logic [31:0] rev;
        logic        retire_old;

        state_next       = state_reg;
        req_next         = req_reg;
        world_next       = world_reg;
        key_next         = key_reg;
        kvalid_next      = kvalid_reg;
        skin_next        = skin_reg;
        count_next       = count_reg;
        frame_next       = frame_reg;
        done_next        = done_reg;
        ranges_used_next = ranges_used_reg;
        cur_world_next   = cur_world_reg;
        cur_gen_next     = cur_gen_reg;
        next_gen_next    = next_gen_reg;
        cap_next         = cap_reg;
        used_next        = used_reg;
        av_next          = av_reg;
        ar_next          = ar_reg;
        pend_used_next   = pend_used_reg;
        scan_next        = scan_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        found_next       = found_reg;
        idx_next         = idx_reg;
        need_next        = need_reg;
        cap_w_next       = cap_w_reg;
        rel_i_next       = rel_i_reg;
        rel_j_next       = rel_j_reg;
        rel_cnt_next     = rel_cnt_reg;
        st_next          = st_reg;
        ovo_next         = ovo_reg;
        ocnt_next        = ocnt_reg;
        orev_next        = orev_reg;
        boff_next        = boff_reg;
        bcnt_next        = bcnt_reg;
        out_valid_next   = out_valid_reg;
        o_status_next    = o_status_reg;
        o_voff_next      = o_voff_reg;
        o_boff_next      = o_boff_reg;
        o_bcnt_next      = o_bcnt_reg;
        o_rev_next       = o_rev_reg;
        o_gen_next       = o_gen_reg;
        o_cap_next       = o_cap_reg;
        o_rel_next       = o_rel_reg;
        o_pend_next      = o_pend_reg;
        o_av_next        = o_av_reg;
        o_ar_next        = o_ar_reg;

        rm_we    = 1'b0;
        rm_re    = 1'b0;
        rm_waddr = idx_reg;
        rm_raddr = scan_reg[RAW-1:0];
        rm_wdata = rm_rdata_reg;
        pm_we    = 1'b0;
        pm_re    = 1'b0;
        pm_waddr = pend_used_reg[PAW-1:0];
        pm_raddr = rel_i_reg[PAW-1:0];
        pm_wdata = '{gen: cur_gen_reg, capacity: cap_reg, frame: frame_reg};

        e          = rm_rdata_reg;
        p          = pm_rdata_reg;
        required   = {1'b0, used_reg} + {1'b0, count_reg};
        new_cap    = cap_w_reg;
        gen_a      = next_gen_reg;
        rev        = rm_rdata_reg.revision + 32'd1;
        retire_old = (cur_gen_reg != 32'd0) && (cap_reg != 32'd0);

        // result leaves the output register
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            gbra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = req_type;
                    world_next   = world_gen;
                    key_next     = key_id;
                    kvalid_next  = key_valid;
                    skin_next    = key_is_skinned;
                    count_next   = vertex_count;
                    frame_next   = frame_index;
                    done_next    = completed_gen;
                    ovo_next     = '0;
                    ocnt_next    = '0;
                    orev_next    = '0;
                    rel_cnt_next = '0;
                    state_next   = gbra_pkg::S_EXEC;
                end
            end

            gbra_pkg::S_EXEC:
            begin
                state_next = gbra_pkg::S_MUL_OFF;
                case (req_reg)
                    gbra_pkg::REQ_BEGIN:
                    begin
                        if (world_reg == 32'd0)
                            st_next = gbra_pkg::ST_WORLD_REJECT;
                        else if (world_reg == cur_world_reg)
                            st_next = gbra_pkg::ST_WORLD_BEGUN;
                        else if (cur_world_reg != 32'd0 && retire_old &&
                                 pend_used_reg >= PCW'(gbra_pkg::MAX_PENDING))
                            st_next = gbra_pkg::ST_CAP_EXCEEDED;
                        else
                        begin
                            if (cur_world_reg != 32'd0 && retire_old)
                            begin
                                pm_we          = 1'b1;
                                pend_used_next = pend_used_reg + PCW'(1);
                            end
                            // entries past ranges in use are never read, so
                            // emptying the table needs no clearing pass
                            ranges_used_next = '0;
                            cur_world_next   = world_reg;
                            cur_gen_next     = '0;
                            cap_next         = '0;
                            used_next        = '0;
                            av_next          = '0;
                            ar_next          = '0;
                            st_next          = gbra_pkg::ST_WORLD_BEGUN;
                        end
                    end
                    gbra_pkg::REQ_OBSERVE:
                    begin
                        if (cur_world_reg == 32'd0 || world_reg != cur_world_reg)
                            st_next = gbra_pkg::ST_BAD_WORLD;
                        else if (!kvalid_reg || !skin_reg)
                            st_next = gbra_pkg::ST_BAD_KEY;
                        else if (count_reg == 32'd0)
                            st_next = gbra_pkg::ST_BAD_COUNT;
                        else if (stride_reg == 16'd0)
                            st_next = gbra_pkg::ST_BAD_STRIDE;
                        else
                        begin
                            scan_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = gbra_pkg::S_SCAN;
                        end
                    end
                    gbra_pkg::REQ_RETIRE:
                    begin
                        if (!kvalid_reg)
                            st_next = gbra_pkg::ST_BAD_KEY;
                        else if (!skin_reg || world_reg != cur_world_reg)
                            st_next = gbra_pkg::ST_NOT_FOUND;
                        else
                        begin
                            scan_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = gbra_pkg::S_SCAN;
                        end
                    end
                    default:
                    begin
                        rel_i_next = '0;
                        rel_j_next = '0;
                        st_next    = gbra_pkg::ST_RELEASED;
                        if (pend_used_reg != '0)
                            state_next = gbra_pkg::S_REL_RD;
                    end
                endcase
            end

            // one table read per cycle, compare on the registered read data
            gbra_pkg::S_SCAN:
            begin
                if (chk_valid_reg && e.key == key_reg)
                begin
                    found_next = 1'b1;
                    idx_next   = chk_idx_reg;
                    state_next = gbra_pkg::S_DECIDE;
                end
                else if (scan_reg < ranges_used_reg)
                begin
                    rm_re          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[RAW-1:0];
                    scan_next      = scan_reg + RCW'(1);
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = gbra_pkg::S_DECIDE;
                end
            end

            gbra_pkg::S_DECIDE:
            begin
                state_next = gbra_pkg::S_MUL_OFF;
                if (req_reg == gbra_pkg::REQ_OBSERVE)
                begin
                    need_next = required;
                    if (found_reg && !e.active)
                    begin
                        st_next   = gbra_pkg::ST_RETIRED_KEY;
                        ovo_next  = e.offset;
                        ocnt_next = e.count;
                        orev_next = e.revision;
                    end
                    else if (found_reg && e.count == count_reg)
                    begin
                        rm_we               = 1'b1;
                        rm_wdata.last_frame = frame_reg;
                        st_next             = gbra_pkg::ST_REUSED;
                        ovo_next            = e.offset;
                        ocnt_next           = e.count;
                        orev_next           = e.revision;
                    end
                    else if (!found_reg &&
                             ranges_used_reg >= RCW'(gbra_pkg::MAX_RANGES))
                        st_next = gbra_pkg::ST_CAP_EXCEEDED;
                    else if (required <= {1'b0, cap_reg})
                        state_next = gbra_pkg::S_APPLY;
                    else if (required > {1'b0, max_cap_reg})
                        st_next = gbra_pkg::ST_CAP_EXCEEDED;
                    else
                    begin
                        // starting size: current, else initial, at least one, at most the maximum
                        new_cap = (cap_reg != 32'd0) ? cap_reg : init_cap_reg;
                        if (new_cap == 32'd0)
                            new_cap = 32'd1;
                        if (new_cap > max_cap_reg)
                            new_cap = max_cap_reg;
                        cap_w_next = new_cap;
                        state_next = gbra_pkg::S_GROW;
                    end
                end
                else
                begin
                    if (!found_reg)
                        st_next = gbra_pkg::ST_NOT_FOUND;
                    else
                    begin
                        ovo_next  = e.offset;
                        ocnt_next = e.count;
                        orev_next = e.revision;
                        if (!e.active)
                            st_next = gbra_pkg::ST_ALREADY_RET;
                        else
                        begin
                            rm_we               = 1'b1;
                            rm_wdata.active     = 1'b0;
                            rm_wdata.last_frame = frame_reg;
                            av_next             = av_reg - e.count;
                            ar_next             = ar_reg - RCW'(1);
                            st_next             = gbra_pkg::ST_RETIRED;
                        end
                    end
                end
            end

            // one doubling step per cycle, saturating at the maximum
            gbra_pkg::S_GROW:
            begin
                if ({1'b0, cap_w_reg} < need_reg)
                begin
                    if (cap_w_reg > max_cap_reg - cap_w_reg)
                        new_cap = max_cap_reg;
                    else
                        new_cap = {cap_w_reg[30:0], 1'b0};
                    cap_w_next = new_cap;
                    if ({1'b0, new_cap} < need_reg && new_cap == max_cap_reg)
                    begin
                        st_next    = gbra_pkg::ST_CAP_EXCEEDED;
                        state_next = gbra_pkg::S_MUL_OFF;
                    end
                end
                else if (retire_old && pend_used_reg >= PCW'(gbra_pkg::MAX_PENDING))
                begin
                    st_next    = gbra_pkg::ST_CAP_EXCEEDED;
                    state_next = gbra_pkg::S_MUL_OFF;
                end
                else
                begin
                    if (retire_old)
                    begin
                        pm_we          = 1'b1;
                        pend_used_next = pend_used_reg + PCW'(1);
                    end
                    // generation zero is skipped on wrap
                    if (next_gen_reg == 32'd0)
                    begin
                        gen_a         = next_gen_reg + 32'd1;
                        next_gen_next = next_gen_reg + 32'd2;
                    end
                    else
                    begin
                        gen_a         = next_gen_reg;
                        next_gen_next = next_gen_reg + 32'd1;
                    end
                    cur_gen_next = gen_a;
                    cap_next     = cap_w_reg;
                    state_next   = gbra_pkg::S_APPLY;
                end
            end

            gbra_pkg::S_APPLY:
            begin
                state_next = gbra_pkg::S_MUL_OFF;
                used_next  = need_reg[31:0];
                ovo_next   = used_reg;
                ocnt_next  = count_reg;
                rm_we      = 1'b1;
                if (found_reg)
                begin
                    if (rev == 32'd0)
                        rev = 32'd1;
                    rm_wdata.offset     = used_reg;
                    rm_wdata.count      = count_reg;
                    rm_wdata.revision   = rev;
                    rm_wdata.last_frame = frame_reg;
                    av_next             = av_reg - e.count + count_reg;
                    orev_next           = rev;
                    st_next             = gbra_pkg::ST_RESIZED;
                end
                else
                begin
                    rm_waddr = ranges_used_reg[RAW-1:0];
                    rm_wdata = '{key: key_reg, offset: used_reg, count: count_reg,
                                 revision: 32'd1, first_frame: frame_reg,
                                 last_frame: frame_reg, active: 1'b1};
                    ranges_used_next = ranges_used_reg + RCW'(1);
                    av_next          = av_reg + count_reg;
                    ar_next          = ar_reg + RCW'(1);
                    orev_next        = 32'd1;
                    st_next          = gbra_pkg::ST_ADDED;
                end
            end

            // pending list compaction, read then keep or drop
            gbra_pkg::S_REL_RD:
            begin
                pm_re      = 1'b1;
                state_next = gbra_pkg::S_REL_CHK;
            end

            gbra_pkg::S_REL_CHK:
            begin
                if (p.gen <= done_reg)
                    rel_cnt_next = rel_cnt_reg + PCW'(1);
                else
                begin
                    pm_we      = 1'b1;
                    pm_waddr   = rel_j_reg[PAW-1:0];
                    pm_wdata   = p;
                    rel_j_next = rel_j_reg + PCW'(1);
                end
                rel_i_next = rel_i_reg + PCW'(1);
                if (rel_i_reg + PCW'(1) < pend_used_reg)
                    state_next = gbra_pkg::S_REL_RD;
                else
                begin
                    pend_used_next = rel_j_next;
                    state_next     = gbra_pkg::S_MUL_OFF;
                end
            end

            gbra_pkg::S_MUL_OFF:
            begin
                boff_next  = mul_p;
                state_next = gbra_pkg::S_MUL_CNT;
            end

            gbra_pkg::S_MUL_CNT:
            begin
                bcnt_next  = mul_p;
                state_next = gbra_pkg::S_DONE;
            end

            // hand the result over once the output register is free
            gbra_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = st_reg;
                    o_voff_next    = ovo_reg;
                    o_boff_next    = boff_reg;
                    o_bcnt_next    = bcnt_reg;
                    o_rev_next     = orev_reg;
                    o_gen_next     = cur_gen_reg;
                    o_cap_next     = cap_reg;
                    o_rel_next     = rel_cnt_reg;
                    o_pend_next    = pend_used_reg;
                    o_av_next      = av_reg;
                    o_ar_next      = ar_reg;
                    state_next     = gbra_pkg::S_IDLE;
                end
            end

            default:
                state_next = gbra_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gbra_pkg::S_IDLE;
            ranges_used_reg  <= '0;
            cur_world_reg    <= '0;
            cur_gen_reg      <= '0;
            next_gen_reg     <= 32'd1;
            cap_reg          <= '0;
            used_reg         <= '0;
            av_reg           <= '0;
            ar_reg           <= '0;
            pend_used_reg    <= '0;
            scan_reg         <= '0;
            chk_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            rel_i_reg        <= '0;
            rel_j_reg        <= '0;
            rel_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ranges_used_reg  <= ranges_used_next;
            cur_world_reg    <= cur_world_next;
            cur_gen_reg      <= cur_gen_next;
            next_gen_reg     <= next_gen_next;
            cap_reg          <= cap_next;
            used_reg         <= used_next;
            av_reg           <= av_next;
            ar_reg           <= ar_next;
            pend_used_reg    <= pend_used_next;
            scan_reg         <= scan_next;
            chk_valid_reg    <= chk_valid_next;
            found_reg        <= found_next;
            rel_i_reg        <= rel_i_next;
            rel_j_reg        <= rel_j_next;
            rel_cnt_reg      <= rel_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        world_reg    <= world_next;
        key_reg      <= key_next;
        kvalid_reg   <= kvalid_next;
        skin_reg     <= skin_next;
        count_reg    <= count_next;
        frame_reg    <= frame_next;
        done_reg     <= done_next;
        chk_idx_reg  <= chk_idx_next;
        idx_reg      <= idx_next;
        need_reg     <= need_next;
        cap_w_reg    <= cap_w_next;
        st_reg       <= st_next;
        ovo_reg      <= ovo_next;
        ocnt_reg     <= ocnt_next;
        orev_reg     <= orev_next;
        boff_reg     <= boff_next;
        bcnt_reg     <= bcnt_next;
        o_status_reg <= o_status_next;
        o_voff_reg   <= o_voff_next;
        o_boff_reg   <= o_boff_next;
        o_bcnt_reg   <= o_bcnt_next;
        o_rev_reg    <= o_rev_next;
        o_gen_reg    <= o_gen_next;
        o_cap_reg    <= o_cap_next;
        o_rel_reg    <= o_rel_next;
        o_pend_reg   <= o_pend_next;
        o_av_reg     <= o_av_next;
        o_ar_reg     <= o_ar_next;
    end

    // Ports
    assign in_stall            = (state_reg != gbra_pkg::S_IDLE);
    assign out_valid           = out_valid_reg;
    assign status              = o_status_reg;
    assign vertex_offset       = o_voff_reg;
    assign byte_offset         = o_boff_reg;
    assign byte_count          = o_bcnt_reg;
    assign alloc_revision      = o_rev_reg;
    assign storage_gen_out     = o_gen_reg;
    assign capacity_out        = o_cap_reg;
    assign released_count      = o_rel_reg;
    assign pending_count       = o_pend_reg;
    assign active_vertices_out = o_av_reg;
    assign active_ranges_out   = o_ar_reg;

    // Checks
    a_ranges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ar_reg <= ranges_used_reg)
        else $error("active ranges exceed ranges in use");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_used_reg <= PCW'(gbra_pkg::MAX_PENDING))
        else $error("pending list overflow");

    a_gen_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_gen_reg == 32'd0) == (cap_reg == 32'd0))
        else $error("storage generation and capacity disagree");

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= cap_reg)
        else $error("bump pointer beyond capacity");

    a_grow_safe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gbra_pkg::S_GROW |-> cap_w_reg <= max_cap_reg)
        else $error("growth step beyond maximum capacity");

endmodule
